>>> rtl/tzr_pkg.sv
// Shared constants, codes and types of the triangle z-buffer rasterizer.
`default_nettype none
package tzr_pkg;
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;
	localparam int DEPTH_BITS     = 24;
	localparam int SUBPIXEL_BITS  = 4;
	localparam int WEIGHT_BITS    = 24;
	localparam int WGT_W          = WEIGHT_BITS + 1;
	localparam int MUL_W          = 26;
	localparam int PROD_W         = 2 * MUL_W;
	localparam int EDGE_W         = 40;
	localparam int ZV_W           = 29;
	localparam int CFG_W          = 16;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_CULLED    = 2'd1;
	localparam logic [1:0] STAT_OFFSCREEN = 2'd2;

	localparam logic [1:0] PASS_OPAQUE = 2'd0;
	localparam logic [1:0] PASS_OFFSET = 2'd1;
	localparam logic [1:0] PASS_BLEND  = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_OFFSET = 2'd2;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_depth;
	} mem_ctl_t;

	function automatic logic [1:0] pass_of(input logic [2:0] mode);
		logic [1:0] p;
		case (mode) inside
			3'd0, 3'd3, 3'd6: p = PASS_OPAQUE;
			3'd1, 3'd4, 3'd7: p = PASS_OFFSET;
			default:          p = PASS_BLEND;
		endcase
		return p;
	endfunction
endpackage
`default_nettype wire

>>> rtl/tzr_req_if.sv
// Triangle/operation request channel.
`default_nettype none
interface tzr_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          operation;
	logic signed [15:0]  vx0;
	logic signed [15:0]  vy0;
	logic signed [15:0]  vx1;
	logic signed [15:0]  vy1;
	logic signed [15:0]  vx2;
	logic signed [15:0]  vy2;
	logic [23:0]         depth0;
	logic [23:0]         depth1;
	logic [23:0]         depth2;
	logic [31:0]         tri_color;
	logic [2:0]          draw_mode;

	modport source(output valid, operation, vx0, vy0, vx1, vy1, vx2, vy2,
		depth0, depth1, depth2, tri_color, draw_mode, input ready);
	modport sink(input valid, operation, vx0, vy0, vx1, vy1, vx2, vy2,
		depth0, depth1, depth2, tri_color, draw_mode, output ready);
endinterface
`default_nettype wire

>>> rtl/tzr_rsp_if.sv
// Result channel.
`default_nettype none
interface tzr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_color;
	logic [18:0] pixels_written;
	logic [1:0]  status;

	modport source(output valid, read_color, pixels_written, status, input ready);
	modport sink(input valid, read_color, pixels_written, status, output ready);
endinterface
`default_nettype wire

>>> rtl/tzr_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module tzr_mul (
	input  wire logic                                   clk,
	input  wire logic signed [tzr_pkg::MUL_W-1:0]       a,
	input  wire logic signed [tzr_pkg::MUL_W-1:0]       b,
	output logic signed [tzr_pkg::PROD_W-1:0]           p_q
);
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end
endmodule
`default_nettype wire

>>> rtl/tzr_div.sv
// Restoring divider, one quotient bit per cycle, for barycentric weights.
`default_nettype none
module tzr_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [tzr_pkg::EDGE_W-1:0]     num,
	input  wire logic [tzr_pkg::EDGE_W-1:0]     den,
	output logic [tzr_pkg::WGT_W-1:0]           quo_q,
	output logic                                done_q
);
	localparam int DW = tzr_pkg::EDGE_W;
	localparam int QW = tzr_pkg::WGT_W;
	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          ge;
	logic [DW:0]   diff;

	always_comb begin
		ge   = rem_q >= {1'b0, den_q};
		diff = ge ? rem_q - {1'b0, den_q} : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {diff[DW-1:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

>>> rtl/tzr_frame_mem.sv
// Depth and color frame store, one port, registered read.
`default_nettype none
module tzr_frame_mem #(
	parameter int AW = 18
) (
	input  wire logic                               clk,
	input  wire tzr_pkg::mem_ctl_t                  ctl,
	input  wire logic [AW-1:0]                      addr,
	input  wire logic [tzr_pkg::DEPTH_BITS-1:0]     wdepth,
	input  wire logic [31:0]                        wcolor,
	output logic [tzr_pkg::DEPTH_BITS-1:0]          rdepth_q,
	output logic [31:0]                             rcolor_q
);
	logic [tzr_pkg::DEPTH_BITS-1:0] depth_mem [2**AW];
	logic [31:0]                    color_mem [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_depth) begin
			depth_mem[addr] <= wdepth;
		end
		if (ctl.rd_en) begin
			rdepth_q <= depth_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			color_mem[addr] <= wcolor;
		end
		if (ctl.rd_en) begin
			rcolor_q <= color_mem[addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/triangle_zbuffer_rasterizer_core.sv
// Triangle rasterizer with z-buffer: sequencer, setup and pixel loop.
// Usage: req carries one operation per transfer (clear, draw triangle, read
// pixel); rsp returns one result per operation. Registers are written via
// cfg_we/cfg_index/cfg_data while the block is idle; the user is bound to this, the block does not enforce it.
// req.ready is high only while the sequencer is idle; one operation at a time.
// Clear: one cycle per store entry, over all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT))
//   entries (262144 at 512x512).
// Read: a store read issue and a data capture. Draw: setup of the signed area,
//   then per bounding-box pixel edge evaluation on the shared multiplier, a test and a
//   step; covered pixels add two weight divisions, a depth interpolation on the
//   multiplier and a store read and compare-write; then the result.
// After reset the registers hold 512, 512, 336; the frame store is undefined
// until a clear has run.
// The result sits in an output register; a stalled receiver holds it while
// the next operation is accepted and processed, and that operation waits
// for the register to empty before it finishes.
`default_nettype none
module triangle_zbuffer_rasterizer_core #(
	parameter int MAX_WIDTH  = tzr_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = tzr_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	tzr_req_if.sink                         req,
	tzr_rsp_if.source                       rsp,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_index,
	input  wire logic [tzr_pkg::CFG_W-1:0]  cfg_data
);
	localparam int XW  = $clog2(MAX_WIDTH);
	localparam int YW  = $clog2(MAX_HEIGHT);
	localparam int AW  = XW + YW;
	localparam int DB  = tzr_pkg::DEPTH_BITS;
	localparam int SUB = tzr_pkg::SUBPIXEL_BITS;
	localparam int EW  = tzr_pkg::EDGE_W;
	localparam int MW  = tzr_pkg::MUL_W;
	localparam int PW  = tzr_pkg::PROD_W;
	localparam int QW  = tzr_pkg::WGT_W;
	localparam int ZW  = tzr_pkg::ZV_W;
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
	localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);
	localparam logic signed [17:0] RND = 18'((1 << SUB) - 1);
	localparam logic signed [ZW-1:0] ZMAX = ZW'((64'd1 << DB) - 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_RD_ISSUE, ST_RD_DATA, ST_EDGE, ST_EVAL, ST_BBOX,
		ST_DIV1_GO, ST_DIV1_WAIT, ST_DIV2_GO, ST_DIV2_WAIT, ST_ZMUL,
		ST_MEM_RD, ST_MEM_CMP, ST_NEXT, ST_OUT
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic area_mode_q;

	logic [9:0]  width_q, height_q;
	logic [15:0] offset_q;

	logic signed [15:0] rx_q [3];
	logic signed [15:0] ry_q [3];
	logic signed [25:0] z_q [3];
	logic [31:0] color_q;
	logic [1:0]  pass_q;
	logic        dbl_q;

	logic signed [EW-1:0] e_q [3];
	logic signed [PW-1:0] t_q;
	logic [EW-1:0] aarea_q;
	logic          area_neg_q;
	logic [XW-1:0] minx_q, maxx_q, px_q;
	logic [YW-1:0] miny_q, maxy_q, py_q;
	logic [QW-1:0] w1_q, w2_q;
	logic signed [ZW-1:0] zv_q;
	logic [18:0] cnt_q;
	logic [31:0] res_color_q;
	logic [1:0]  res_status_q;
	logic [AW-1:0] clr_addr_q;

	logic        ov_q;
	logic [31:0] out_color_q;
	logic [18:0] out_cnt_q;
	logic [1:0]  out_status_q;

	logic [12:0] wdim, hdim;
	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	logic        div_start, div_done;
	logic [EW-1:0] div_num;
	logic [QW-1:0] div_quo;
	tzr_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0] mem_addr;
	logic [DB-1:0] mem_wdepth, mem_rdepth;
	logic [31:0]   mem_wcolor, mem_rcolor, blend;
	logic          zpass;
	logic          accept;

	logic signed [16:0] xs [3];
	logic signed [16:0] ys [3];
	logic signed [19:0] ptx, pty, axk, ayk, dxk, dyk;
	logic [1:0] ka, kb;
	logic signed [PW:0] zsum;
	logic signed [ZW-1:0] zv_new;
	logic signed [EW-1:0] e_new;
	logic signed [15:0] rxmin, rxmax, rymin, rymax;
	logic signed [17:0] bx_lo, bx_hi, by_lo, by_hi, wlast, hlast;
	logic bbox_empty, in_tri, rd_outside;
	logic signed [25:0] zin [3];
	logic [23:0] din [3];
	logic [1:0] req_pass;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = ov_q;
	assign rsp.read_color     = out_color_q;
	assign rsp.pixels_written = out_cnt_q;
	assign rsp.status         = out_status_q;

	always_comb begin
		wdim = (width_q == 10'd0) ? 13'd1 :
			({3'b0, width_q} > MAXW) ? MAXW : {3'b0, width_q};
		hdim = (height_q == 10'd0) ? 13'd1 :
			({3'b0, height_q} > MAXH) ? MAXH : {3'b0, height_q};
		wlast = $signed({5'b0, wdim}) - 18'sd1;
		hlast = $signed({5'b0, hdim}) - 18'sd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 10'd512;
			height_q <= 10'd512;
			offset_q <= 16'd336;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tzr_pkg::REG_WIDTH:  width_q  <= cfg_data[9:0];
				tzr_pkg::REG_HEIGHT: height_q <= cfg_data[9:0];
				tzr_pkg::REG_OFFSET: offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input decode
	always_comb begin
		req_pass = tzr_pkg::pass_of(req.draw_mode);
		din[0] = req.depth0;
		din[1] = req.depth1;
		din[2] = req.depth2;
		for (int i = 0; i < 3; i++) begin
			zin[i] = $signed({2'b0, din[i]}) -
				((req_pass == tzr_pkg::PASS_OFFSET) ? $signed({10'b0, offset_q}) : 26'sd0);
		end
		rd_outside = req.vx0[15] || req.vy0[15] ||
			(req.vx0 >= $signed({3'b0, wdim})) || (req.vy0 >= $signed({3'b0, hdim}));
	end

	// Shared multiplier operand selection, edge/depth accumulation and inside test
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xs[i] = $signed({rx_q[i], 1'b0});
			ys[i] = $signed({ry_q[i], 1'b0});
		end
		case (step_q[2:1])
			2'd0:    begin ka = 2'd1; kb = 2'd2; end
			2'd1:    begin ka = 2'd2; kb = 2'd0; end
			default: begin ka = 2'd0; kb = 2'd1; end
		endcase
		if (area_mode_q) begin
			ptx = 20'(xs[2]);
			pty = 20'(ys[2]);
		end else begin
			ptx = $signed(20'({px_q, 1'b1}) << SUB);
			pty = $signed(20'({py_q, 1'b1}) << SUB);
		end
		axk = 20'(xs[ka]);
		ayk = 20'(ys[ka]);
		dxk = 20'(xs[kb]) - 20'(xs[ka]);
		dyk = 20'(ys[kb]) - 20'(ys[ka]);
		if (state_q == ST_ZMUL) begin
			if (step_q == 3'd0) begin
				mul_a = $signed({1'b0, w1_q});
				mul_b = z_q[1] - z_q[0];
			end else begin
				mul_a = $signed({1'b0, w2_q});
				mul_b = z_q[2] - z_q[0];
			end
		end else if (!step_q[0]) begin
			mul_a = MW'(ptx - axk);
			mul_b = MW'(dyk);
		end else begin
			mul_a = MW'(pty - ayk);
			mul_b = MW'(dxk);
		end
		e_new  = $signed(t_q[EW-1:0]) - $signed(mul_p[EW-1:0]);
		zsum   = (PW+1)'(t_q) + (PW+1)'(mul_p);
		zv_new = ZW'(z_q[0]) + ZW'(zsum >>> tzr_pkg::WEIGHT_BITS);
		in_tri = area_neg_q ?
			(e_q[0] <= 0 && e_q[1] <= 0 && e_q[2] <= 0) :
			(e_q[0] >= 0 && e_q[1] >= 0 && e_q[2] >= 0);
	end

	// Bounding box, clipped to the active frame
	always_comb begin
		rxmin = rx_q[0]; rxmax = rx_q[0];
		rymin = ry_q[0]; rymax = ry_q[0];
		for (int i = 1; i < 3; i++) begin
			if (rx_q[i] < rxmin) rxmin = rx_q[i];
			if (rx_q[i] > rxmax) rxmax = rx_q[i];
			if (ry_q[i] < rymin) rymin = ry_q[i];
			if (ry_q[i] > rymax) rymax = ry_q[i];
		end
		bx_lo = 18'(rxmin >>> SUB);
		by_lo = 18'(rymin >>> SUB);
		bx_hi = (18'(rxmax) + RND) >>> SUB;
		by_hi = (18'(rymax) + RND) >>> SUB;
		if (bx_lo < 0) bx_lo = '0;
		if (by_lo < 0) by_lo = '0;
		if (bx_hi > wlast) bx_hi = wlast;
		if (by_hi > hlast) by_hi = hlast;
		bbox_empty = (bx_lo > bx_hi) || (by_lo > by_hi);
	end

	// Depth test and alpha blend on the stored pixel
	always_comb begin
		logic [7:0]  sc, dc, al;
		logic [15:0] v;
		logic [16:0] r;
		al = color_q[31:24];
		blend = 32'hFF00_0000;
		for (int c = 0; c < 3; c++) begin
			sc = color_q[8*c +: 8];
			dc = mem_rcolor[8*c +: 8];
			v  = 16'(sc) * 16'(al) + 16'(dc) * 16'(8'd255 - al);
			r  = 17'(v) + 17'(v >> 8) + 17'd1;
			blend[8*c +: 8] = r[15:8];
		end
		zpass = (zv_q >= 0) && (zv_q <= ZMAX) &&
			(zv_q <= $signed({{(ZW-DB){1'b0}}, mem_rdepth}));
	end

	always_comb begin
		mem_ctl.rd_en    = (state_q == ST_MEM_RD) || (state_q == ST_RD_ISSUE);
		mem_ctl.wr_en    = (state_q == ST_CLEAR) || ((state_q == ST_MEM_CMP) && zpass);
		mem_ctl.wr_depth = (state_q == ST_CLEAR) ||
			((state_q == ST_MEM_CMP) && zpass && (pass_q != tzr_pkg::PASS_BLEND));
		mem_addr   = (state_q == ST_CLEAR) ? clr_addr_q : {py_q, px_q};
		mem_wdepth = (state_q == ST_CLEAR) ? {DB{1'b1}} : zv_q[DB-1:0];
		mem_wcolor = (state_q == ST_CLEAR) ? 32'd0 :
			(pass_q == tzr_pkg::PASS_BLEND) ? blend : color_q;
		div_start  = (state_q == ST_DIV1_GO) || (state_q == ST_DIV2_GO);
		div_num    = (state_q == ST_DIV1_GO) ?
			(e_q[1][EW-1] ? EW'(-e_q[1]) : EW'(e_q[1])) :
			(e_q[2][EW-1] ? EW'(-e_q[2]) : EW'(e_q[2]));
	end

	tzr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	tzr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (aarea_q),
		.quo_q  (div_quo),
		.done_q (div_done)
	);

	tzr_frame_mem #(.AW(AW)) u_mem (
		.clk      (clk),
		.ctl      (mem_ctl),
		.addr     (mem_addr),
		.wdepth   (mem_wdepth),
		.wcolor   (mem_wcolor),
		.rdepth_q (mem_rdepth),
		.rcolor_q (mem_rcolor)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			area_mode_q <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			if (ov_q && rsp.ready && (state_q != ST_OUT)) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rx_q[0] <= req.vx0; ry_q[0] <= req.vy0;
						rx_q[1] <= req.vx1; ry_q[1] <= req.vy1;
						rx_q[2] <= req.vx2; ry_q[2] <= req.vy2;
						for (int i = 0; i < 3; i++) z_q[i] <= zin[i];
						color_q      <= req.tri_color;
						pass_q       <= req_pass;
						dbl_q        <= req.draw_mode >= 3'd3;
						cnt_q        <= '0;
						res_color_q  <= '0;
						res_status_q <= tzr_pkg::STAT_DONE;
						step_q       <= '0;
						unique case (req.operation)
							tzr_pkg::OP_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							tzr_pkg::OP_DRAW: begin
								area_mode_q <= 1'b1;
								state_q     <= ST_EDGE;
							end
							tzr_pkg::OP_READ: begin
								px_q <= req.vx0[XW-1:0];
								py_q <= req.vy0[YW-1:0];
								if (rd_outside) begin
									res_status_q <= tzr_pkg::STAT_OFFSCREEN;
									state_q      <= ST_OUT;
								end else begin
									state_q <= ST_RD_ISSUE;
								end
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == {AW{1'b1}}) state_q <= ST_OUT;
				end
				ST_RD_ISSUE: state_q <= ST_RD_DATA;
				ST_RD_DATA: begin
					res_color_q <= mem_rcolor;
					state_q     <= ST_OUT;
				end
				ST_EDGE: begin
					step_q <= step_q + 1'b1;
					if (step_q[0]) t_q <= mul_p;
					unique case (step_q)
						3'd2: e_q[0] <= e_new;
						3'd4: e_q[1] <= e_new;
						3'd6: e_q[2] <= e_new;
						default: ;
					endcase
					if (step_q == 3'd6) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (area_mode_q) begin
						if (e_q[2] == 0 || (e_q[2] < 0 && !dbl_q)) begin
							res_status_q <= tzr_pkg::STAT_CULLED;
							state_q      <= ST_OUT;
						end else begin
							aarea_q    <= e_q[2][EW-1] ? EW'(-e_q[2]) : EW'(e_q[2]);
							area_neg_q <= e_q[2][EW-1];
							state_q    <= ST_BBOX;
						end
					end else begin
						state_q <= in_tri ? ST_DIV1_GO : ST_NEXT;
					end
				end
				ST_BBOX: begin
					if (bbox_empty) begin
						res_status_q <= tzr_pkg::STAT_OFFSCREEN;
						state_q      <= ST_OUT;
					end else begin
						minx_q      <= bx_lo[XW-1:0];
						maxx_q      <= bx_hi[XW-1:0];
						miny_q      <= by_lo[YW-1:0];
						maxy_q      <= by_hi[YW-1:0];
						px_q        <= bx_lo[XW-1:0];
						py_q        <= by_lo[YW-1:0];
						area_mode_q <= 1'b0;
						step_q      <= '0;
						state_q     <= ST_EDGE;
					end
				end
				ST_DIV1_GO: state_q <= ST_DIV1_WAIT;
				ST_DIV1_WAIT: begin
					if (div_done) begin
						w1_q    <= div_quo;
						state_q <= ST_DIV2_GO;
					end
				end
				ST_DIV2_GO: state_q <= ST_DIV2_WAIT;
				ST_DIV2_WAIT: begin
					if (div_done) begin
						w2_q    <= div_quo;
						step_q  <= '0;
						state_q <= ST_ZMUL;
					end
				end
				ST_ZMUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == 3'd1) t_q <= mul_p;
					if (step_q == 3'd2) begin
						zv_q    <= zv_new;
						state_q <= ST_MEM_RD;
					end
				end
				ST_MEM_RD: state_q <= ST_MEM_CMP;
				ST_MEM_CMP: begin
					if (zpass) cnt_q <= cnt_q + 1'b1;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					step_q <= '0;
					if (px_q == maxx_q) begin
						px_q <= minx_q;
						if (py_q == maxy_q) begin
							state_q <= ST_OUT;
						end else begin
							py_q    <= py_q + 1'b1;
							state_q <= ST_EDGE;
						end
					end else begin
						px_q    <= px_q + 1'b1;
						state_q <= ST_EDGE;
					end
				end
				ST_OUT: begin
					if (!ov_q || rsp.ready) begin
						ov_q         <= 1'b1;
						out_color_q  <= res_color_q;
						out_cnt_q    <= (res_status_q == tzr_pkg::STAT_DONE) ? cnt_q : 19'd0;
						out_status_q <= res_status_q;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
